// File: design/wlts_pkg.sv
// ----------------------------------------------------------------------------
// wlts_pkg
// Shared types and constants of the tempo-synced wavetable oscillator.
// ----------------------------------------------------------------------------
package wlts_pkg;

   // Item kinds on the request channel.
   localparam logic [1:0] KIND_TICK    = 2'd0;
   localparam logic [1:0] KIND_LOAD    = 2'd1;
   localparam logic [1:0] KIND_RESTART = 2'd2;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_RATE_HZ     = 2'd0;
   localparam logic [1:0] CSR_SYNC_ENABLE = 2'd1;
   localparam logic [1:0] CSR_SYNC_BEATS  = 2'd2;
   localparam logic [1:0] CSR_SAMPLE_RATE = 2'd3;

   localparam int CSR_DATA_W = 24;
   localparam int RATE_W     = 24;
   localparam int TEMPO_W    = 18;
   localparam int BLOCK_W    = 13;
   localparam int SAMPLE_W   = 16;
   localparam int SRATE_W    = 18;
   localparam int FRAC_W     = 16;

   // Rate limits in Q8.16 Hz: 0.01 Hz and 200 Hz.
   localparam logic [RATE_W-1:0] RATE_MIN = 24'd655;
   localparam logic [RATE_W-1:0] RATE_MAX = 24'd13107200;

   localparam logic [RATE_W-1:0]  RATE_RESET  = 24'd65536;
   localparam logic [RATE_W-1:0]  BEATS_RESET = 24'd65536;
   localparam logic [SRATE_W-1:0] SRATE_RESET = 18'd48000;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

endpackage

// File: design/wlts_req_if.sv
// ----------------------------------------------------------------------------
// wlts_req_if
// Request channel: ticks, table loads and phase restarts.
// ----------------------------------------------------------------------------
interface wlts_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          kind;
   logic [wlts_pkg::TEMPO_W-1:0]        tempo_bpm;
   logic [wlts_pkg::BLOCK_W-1:0]        block_samples;
   logic signed [wlts_pkg::SAMPLE_W-1:0] sample_value;
   logic                                last_sample;

   modport source (output valid, kind, tempo_bpm, block_samples, sample_value,
                   last_sample, input ready);
   modport sink   (input valid, kind, tempo_bpm, block_samples, sample_value,
                   last_sample, output ready);
endinterface

// File: design/wlts_rsp_if.sv
// ----------------------------------------------------------------------------
// wlts_rsp_if
// Response channel: oscillator value and normalized phase.
// ----------------------------------------------------------------------------
interface wlts_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [wlts_pkg::SAMPLE_W-1:0] lfo_value;
   logic [wlts_pkg::FRAC_W-1:0]          phase_fraction;

   modport source (output valid, lfo_value, phase_fraction, input ready);
   modport sink   (input valid, lfo_value, phase_fraction, output ready);
endinterface

// File: design/wavetable_lfo_tempo_sync.sv
// ----------------------------------------------------------------------------
// wavetable_lfo_tempo_sync
// Low-frequency oscillator read from a double-buffered wavetable.
// ----------------------------------------------------------------------------
// Each word on req_ch is a block tick, a table load or a phase restart. A
// load writes the next entry of the inactive bank, and a load marked last
// swaps the banks; loads and restarts are taken while idle and give no
// word on rsp_ch. A tick gives exactly one rsp_ch word: the interpolated
// table value at the old phase and the advanced phase divided by the depth.
// A tick runs through one shared restoring divider of NUM_W bits (NUM_W is
// 50 at the default depth), one bit per cycle. The depth is a power of two,
// so the phase wraps by subtracting the span and the normalized phase is a
// shift. With tempo sync the divider first derives the rate from the tempo
// and then the phase increment, so such a tick uses it twice.
// req_ch.ready is low while a tick is in flight. The finished word sits in
// an output register, so a new word is taken while rsp_ch is stalled; a
// following tick waits at its end until that register is free.
// Reset clears the control state. Both banks then read as the sine table,
// which comes from a ROM until a load sequence replaces a bank, so there is
// no clearing pass. Configuration writes are taken at any time and are
// meant to arrive while the block is idle.
// ----------------------------------------------------------------------------
module wavetable_lfo_tempo_sync #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   wlts_req_if.sink                           req_ch,
   wlts_rsp_if.source                         rsp_ch,
   input  logic                               csr_we,
   input  logic [1:0]                         csr_index,
   input  logic [wlts_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import wlts_pkg::*;

   // Index, length and phase widths follow the depth.
   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int LEN_W  = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W = $clog2(2 * TABLE_DEPTH);
   localparam int PH_W   = IDX_W + 16;
   localparam int P1_W   = RATE_W + BLOCK_W;
   // Divider widths: the widest dividend is rate*depth*block or tempo<<32,
   // the widest divisor 15360*beats.
   localparam int INC_W  = P1_W + LEN_W;
   localparam int NUM_W  = (INC_W > TEMPO_W + 32) ? INC_W : TEMPO_W + 32;
   localparam int DEN_W  = RATE_W + 14;
   localparam int CNT_W  = $clog2(NUM_W + 1);
   localparam logic [PH_W:0] SPAN = (PH_W + 1)'(TABLE_DEPTH) << 16;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_RATE_DIV = 4'd1;
   localparam logic [3:0] ST_CLAMP    = 4'd2;
   localparam logic [3:0] ST_READ0    = 4'd3;
   localparam logic [3:0] ST_READ1    = 4'd4;
   localparam logic [3:0] ST_INTERP   = 4'd5;
   localparam logic [3:0] ST_INC_DIV  = 4'd6;
   localparam logic [3:0] ST_WRITE    = 4'd9;

   // Taylor series divisors (2k)(2k+1) for k = 1 to 7.
   localparam longint unsigned TAYLOR_DEN [1:7] =
      '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};

   // Sine table built at elaboration: quarter-wave Taylor series in Q30.
   typedef logic signed [SAMPLE_W-1:0] sine_rom_type [TABLE_DEPTH];

   function automatic sine_rom_type build_sine();
      sine_rom_type       rom;
      longint unsigned    t, r, x, x2, term, sum, scaled;
      int unsigned        quad;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         t    = (longint'(i) << 32) >> IDX_W;
         quad = int'((t >> 30) & 3);
         r    = t & 64'h3FFF_FFFF;
         if (quad[0]) begin
            r = 64'h4000_0000 - r;
         end
         x    = (r * 64'd1686629713) >> 30;
         x2   = (x * x) >> 30;
         term = x;
         sum  = x;
         for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / TAYLOR_DEN[k];
            if (k[0]) begin
               sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
               sum = sum + term;
            end
         end
         scaled = (sum * 64'd32767 + 64'h2000_0000) >> 30;
         if (scaled > 64'd32767) begin
            scaled = 64'd32767;
         end
         rom[i] = (quad >= 2) ? -SAMPLE_W'(scaled) : SAMPLE_W'(scaled);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine();

   // Configuration registers.
   logic [RATE_W-1:0]   rate_hz_ff;
   logic                sync_enable_ff;
   logic [RATE_W-1:0]   sync_beats_ff;
   logic [SRATE_W-1:0]  sample_rate_ff;

   // Table state.
   logic [SAMPLE_W-1:0] bank_mem [2 * TABLE_DEPTH];
   logic                active_bank_ff, active_bank_in;
   logic [LEN_W-1:0]    bank_length_ff [2];
   logic [LEN_W-1:0]    bank_length_in [2];
   logic [1:0]          sine_mode_ff, sine_mode_in;
   logic [LEN_W-1:0]    load_pointer_ff, load_pointer_in;
   logic [PH_W-1:0]     phase_ff, phase_in;

   // Sequencer and working registers.
   logic [3:0]          state_ff, state_in;
   logic [BLOCK_W-1:0]  block_ff, block_in;
   logic [NUM_W-1:0]    rate_raw_ff, rate_raw_in;
   logic [RATE_W-1:0]   rate_ff, rate_in;
   logic [P1_W-1:0]     prod1_ff, prod1_in;
   logic [NUM_W-1:0]    num_ff, num_in;
   sample_type          s0_ff, s0_in, s1_ff, s1_in;
   sample_type          interp_ff, interp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   sample_type          lfo_value_ff, lfo_value_in;
   logic [FRAC_W-1:0]   frac_out_ff, frac_out_in;

   // Shared divider.
   logic [DEN_W-1:0]    div_rem_ff;
   logic [NUM_W-1:0]    div_quo_ff;
   logic [DEN_W-1:0]    div_den_ff;
   logic [CNT_W-1:0]    div_cnt_ff;
   logic                div_start;
   logic [NUM_W-1:0]    div_num;
   logic [DEN_W-1:0]    div_den;
   logic [DEN_W:0]      div_shift, div_diff;
   logic                div_done;

   // Read port.
   logic [SAMPLE_W-1:0] mem_q_ff;
   sample_type          rom_q_ff;
   logic                rd_zero_ff;
   logic [IDX_W-1:0]    idx, idx1, rd_idx;
   logic [ADDR_W-1:0]   rd_addr, wr_addr;
   logic                mem_we;
   sample_type          rd_sample;

   // Misc combinational values.
   logic                accept, tick_sync;
   logic [DEN_W-1:0]    sr_eff;
   logic signed [SAMPLE_W:0]   diff;
   logic signed [2*SAMPLE_W+1:0] interp_prod;
   logic [PH_W+1:0]     phase_sum;
   logic [PH_W-1:0]     phase_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_hz_ff     <= RATE_RESET;
         sync_enable_ff <= 1'b0;
         sync_beats_ff  <= BEATS_RESET;
         sample_rate_ff <= SRATE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RATE_HZ:     rate_hz_ff     <= csr_wdata[RATE_W-1:0];
            CSR_SYNC_ENABLE: sync_enable_ff <= csr_wdata[0];
            CSR_SYNC_BEATS:  sync_beats_ff  <= csr_wdata[RATE_W-1:0];
            CSR_SAMPLE_RATE: sample_rate_ff <= csr_wdata[SRATE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign accept    = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign tick_sync = sync_enable_ff && (req_ch.tempo_bpm != '0) && (sync_beats_ff != '0);
   assign sr_eff    = (sample_rate_ff == '0) ? DEN_W'(1) : DEN_W'(sample_rate_ff);

   // Table addressing: the upper index wraps to entry zero.
   assign idx     = phase_ff[PH_W-1:16];
   assign idx1    = (LEN_W'(idx) == LEN_W'(TABLE_DEPTH - 1)) ? '0 : idx + IDX_W'(1);
   assign rd_idx  = (state_ff == ST_CLAMP) ? idx : idx1;
   assign rd_addr = active_bank_ff ? ADDR_W'(rd_idx) + ADDR_W'(TABLE_DEPTH)
                                   : ADDR_W'(rd_idx);
   assign wr_addr = active_bank_ff ? ADDR_W'(load_pointer_ff)
                                   : ADDR_W'(load_pointer_ff) + ADDR_W'(TABLE_DEPTH);
   assign mem_we  = accept && (req_ch.kind == KIND_LOAD) &&
                    (load_pointer_ff < LEN_W'(TABLE_DEPTH));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bank_mem[wr_addr] <= req_ch.sample_value;
      end
      mem_q_ff   <= bank_mem[rd_addr];
      rom_q_ff   <= SINE_ROM[rd_idx];
      rd_zero_ff <= LEN_W'(rd_idx) >= bank_length_ff[active_bank_ff];
   end

   // A bank that still holds its reset contents reads from the sine ROM.
   assign rd_sample = rd_zero_ff ? '0 :
                      sine_mode_ff[active_bank_ff] ? rom_q_ff : sample_type'(mem_q_ff);

   // Divider: one quotient bit per cycle, remainder kept below the divisor.
   assign div_shift = {div_rem_ff, div_quo_ff[NUM_W-1]};
   assign div_diff  = div_shift - {1'b0, div_den_ff};
   assign div_done  = (div_cnt_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (div_start) begin
         div_cnt_ff <= CNT_W'(NUM_W);
      end else if (!div_done) begin
         div_cnt_ff <= div_cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (div_start) begin
         div_rem_ff <= '0;
         div_quo_ff <= div_num;
         div_den_ff <= div_den;
      end else if (!div_done) begin
         div_rem_ff <= div_diff[DEN_W] ? div_shift[DEN_W-1:0] : div_diff[DEN_W-1:0];
         div_quo_ff <= {div_quo_ff[NUM_W-2:0], !div_diff[DEN_W]};
      end
   end

   // Interpolation and phase wrap. The increment is taken modulo the span
   // by keeping its low PH_W bits.
   assign diff        = {s1_ff[SAMPLE_W-1], s1_ff} - {s0_ff[SAMPLE_W-1], s0_ff};
   assign interp_prod = $signed({2'b00, phase_ff[15:0]}) * diff;
   assign phase_sum   = (PH_W + 2)'(phase_ff) + (PH_W + 2)'(div_quo_ff[PH_W-1:0]);
   assign phase_next  = (phase_sum >= (PH_W + 2)'(SPAN))
                        ? PH_W'(phase_sum - (PH_W + 2)'(SPAN)) : PH_W'(phase_sum);

   always_comb begin
      state_in        = state_ff;
      block_in        = block_ff;
      rate_raw_in     = rate_raw_ff;
      rate_in         = rate_ff;
      prod1_in        = prod1_ff;
      num_in          = num_ff;
      s0_in           = s0_ff;
      s1_in           = s1_ff;
      interp_in       = interp_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      lfo_value_in    = lfo_value_ff;
      frac_out_in     = frac_out_ff;
      phase_in        = phase_ff;
      active_bank_in  = active_bank_ff;
      bank_length_in  = bank_length_ff;
      sine_mode_in    = sine_mode_ff;
      load_pointer_in = load_pointer_ff;
      div_start       = 1'b0;
      div_num         = '0;
      div_den         = sr_eff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_ch.kind)
                  KIND_TICK: begin
                     block_in = req_ch.block_samples;
                     if (tick_sync) begin
                        // rate = tempo*2^32 / (15360*beats)
                        div_start = 1'b1;
                        div_num   = NUM_W'({req_ch.tempo_bpm, 32'd0});
                        div_den   = (DEN_W'(sync_beats_ff) << 14)
                                    - (DEN_W'(sync_beats_ff) << 10);
                        state_in  = ST_RATE_DIV;
                     end else begin
                        rate_raw_in = NUM_W'(rate_hz_ff);
                        state_in    = ST_CLAMP;
                     end
                  end
                  KIND_LOAD: begin
                     if (mem_we) begin
                        load_pointer_in = load_pointer_ff + LEN_W'(1);
                     end
                     if (req_ch.last_sample) begin
                        bank_length_in[!active_bank_ff] = load_pointer_in;
                        sine_mode_in[!active_bank_ff]   = 1'b0;
                        active_bank_in  = !active_bank_ff;
                        load_pointer_in = '0;
                     end
                  end
                  KIND_RESTART: begin
                     phase_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RATE_DIV: begin
            if (div_done) begin
               rate_raw_in = div_quo_ff;
               state_in    = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            if (rate_raw_ff < NUM_W'(RATE_MIN)) begin
               rate_in = RATE_MIN;
            end else if (rate_raw_ff > NUM_W'(RATE_MAX)) begin
               rate_in = RATE_MAX;
            end else begin
               rate_in = rate_raw_ff[RATE_W-1:0];
            end
            state_in = ST_READ0;
         end
         ST_READ0: begin
            s0_in    = rd_sample;
            prod1_in = P1_W'(rate_ff) * P1_W'(block_ff);
            state_in = ST_READ1;
         end
         ST_READ1: begin
            s1_in    = rd_sample;
            num_in   = NUM_W'(prod1_ff) * NUM_W'(TABLE_DEPTH);
            state_in = ST_INTERP;
         end
         ST_INTERP: begin
            // Arithmetic shift floors for both signs of the product.
            interp_in = s0_ff + SAMPLE_W'(interp_prod >>> 16);
            div_start = 1'b1;
            div_num   = num_ff;
            div_den   = sr_eff;
            state_in  = ST_INC_DIV;
         end
         ST_INC_DIV: begin
            if (div_done) begin
               phase_in = phase_next;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               lfo_value_in = interp_ff;
               frac_out_in  = phase_ff[PH_W-1:IDX_W];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         rsp_valid_ff      <= 1'b0;
         phase_ff          <= '0;
         active_bank_ff    <= 1'b0;
         bank_length_ff[0] <= LEN_W'(TABLE_DEPTH);
         bank_length_ff[1] <= LEN_W'(TABLE_DEPTH);
         sine_mode_ff      <= 2'b11;
         load_pointer_ff   <= '0;
      end else begin
         state_ff          <= state_in;
         rsp_valid_ff      <= rsp_valid_in;
         phase_ff          <= phase_in;
         active_bank_ff    <= active_bank_in;
         bank_length_ff    <= bank_length_in;
         sine_mode_ff      <= sine_mode_in;
         load_pointer_ff   <= load_pointer_in;
      end
   end

   always_ff @(posedge clock) begin
      block_ff     <= block_in;
      rate_raw_ff  <= rate_raw_in;
      rate_ff      <= rate_in;
      prod1_ff     <= prod1_in;
      num_ff       <= num_in;
      s0_ff        <= s0_in;
      s1_ff        <= s1_in;
      interp_ff    <= interp_in;
      lfo_value_ff <= lfo_value_in;
      frac_out_ff  <= frac_out_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.lfo_value      = lfo_value_ff;
   assign rsp_ch.phase_fraction = frac_out_ff;

   // The phase always stays inside one table span.
   a_phase_in_span: assert property (@(posedge clock) disable iff (reset)
      (PH_W + 1)'(phase_ff) < SPAN)
      else $error("phase accumulator beyond table span");

   // The load pointer never runs past the table depth.
   a_pointer_bound: assert property (@(posedge clock) disable iff (reset)
      load_pointer_ff <= LEN_W'(TABLE_DEPTH))
      else $error("load pointer beyond table depth");

   // The divider is never left running while the block is idle.
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> div_done)
      else $error("divider busy while idle");

   // A finished tick leaves the write state only by filling the output register.
   a_write_fills: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE && state_in == ST_IDLE) |=> rsp_valid_ff)
      else $error("tick finished without a response word");

endmodule
